/* hdl/lpcp_pkg.sv */
`timescale 1ns / 1ps

package lpcp_pkg;

  // Format constants
  localparam int PIXEL_COORD_BITS = 12;
  localparam int COORD_FRAC_BITS  = 12;

  localparam int COORD_W  = 21;
  localparam int COEF_W   = 18;
  localparam int TRANS_W  = 20;
  localparam int FOCAL_W  = 16;
  localparam int DIM_W    = 12;
  localparam int DEPTH_W  = 20;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;

  // Derived widths
  localparam int SQ_W     = 2 * COORD_W;                    // one square
  localparam int RP_W     = COEF_W + COORD_W;               // one rotation product
  localparam int CAM_W    = 42;                             // camera coordinate
  localparam int TSH      = COORD_FRAC_BITS + 4;            // translation / depth shift
  localparam int LSH      = 2 * COORD_FRAC_BITS - 8;        // range limit shift
  localparam int LIM_W    = 32 + LSH;
  localparam int CMP_W    = (LIM_W > SQ_W) ? LIM_W : SQ_W;
  localparam int PA_W     = FOCAL_W + 1 + CAM_W;
  localparam int PB_W     = FOCAL_W + 2 + CAM_W;
  localparam int NUM_W    = PB_W + 1;
  localparam int MAG_W    = NUM_W - 1;
  localparam int Q_W      = PIXEL_COORD_BITS + 1;           // quotient bits before overflow
  localparam int DSH_W    = MAG_W + Q_W;                    // shifted divisor width
  localparam int CLIP_W   = 15;                             // clipped image dimension
  localparam int FRONT_STAGES = 5;
  localparam int LATENCY  = FRONT_STAGES + Q_W + 1;

  typedef enum logic [2:0] {
    ST_VIEW    = 3'd0,
    ST_NOCAM   = 3'd1,
    ST_INVALID = 3'd2,
    ST_RANGE   = 3'd3,
    ST_BEHIND  = 3'd4,
    ST_OUTSIDE = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_X    = 3'd0,
    REG_ROT_Y    = 3'd1,
    REG_ROT_Z    = 3'd2,
    REG_TRANS    = 3'd3,
    REG_FOCAL    = 3'd4,
    REG_RANGE    = 3'd5,
    REG_IMAGE    = 3'd6,
    REG_RESERVED = 3'd7
  } cfg_idx_t;

endpackage

/* hdl/lpcp_div.sv */
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// Gives floor(mag / den) in Q_W bits plus an overflow flag.
module lpcp_div
  import lpcp_pkg::*;
(
  input  logic             clk,
  input  logic [MAG_W-1:0] mag,
  input  logic [MAG_W-1:0] den,
  input  logic             neg,
  output logic [Q_W-1:0]   quo,
  output logic             ovf,
  output logic             neg_out
);

  logic [MAG_W-1:0] rem_st [Q_W+1];
  logic [MAG_W-1:0] den_st [Q_W+1];
  logic [Q_W-1:0]   q_st   [Q_W+1];
  logic             ovf_st [Q_W+1];
  logic             neg_st [Q_W+1];

  // Stage inputs
  assign rem_st[0] = mag;
  assign den_st[0] = den;
  assign q_st[0]   = '0;
  assign neg_st[0] = neg;
  assign ovf_st[0] = ({{Q_W{1'b0}}, mag} >= (DSH_W'(den) << Q_W));

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int SH = Q_W - 1 - k;
    logic [DSH_W-1:0] dsh;
    logic             ge;

    // Trial subtract of the shifted divisor
    assign dsh = DSH_W'(den_st[k]) << SH;
    assign ge  = ({{Q_W{1'b0}}, rem_st[k]} >= dsh);

    always_ff @(posedge clk) begin
      rem_st[k+1] <= ge ? (rem_st[k] - dsh[MAG_W-1:0]) : rem_st[k];
      q_st[k+1]   <= q_st[k] | (Q_W'(ge) << SH);
      den_st[k+1] <= den_st[k];
      ovf_st[k+1] <= ovf_st[k];
      neg_st[k+1] <= neg_st[k];
    end
  end

  assign quo     = q_st[Q_W];
  assign ovf     = ovf_st[Q_W];
  assign neg_out = neg_st[Q_W];

endmodule

/* hdl/lidar_point_camera_projection_top.sv */
`timescale 1ns / 1ps

// Lidar point to camera pixel projection.
// Input channel: a point (point_x/y/z, signed Q8.12 m, point_finite) is taken
// at every rising edge with start high and busy low. busy is always low: the
// pipeline takes one point per cycle, back to back, with no gaps.
// Output channel: one result per point, in input order, shown for exactly one
// cycle with done high: status, pixel_u, pixel_v, camera_depth.
// Pipeline: 5 front stages (register, multiply, sum, range/behind test with the
// projection products, numerator); then one 13-stage restoring divider per image
// axis, one quotient bit per stage; then the output register.
// Throughput: one point per clock.
// Configuration: cfg_we / cfg_index / cfg_data write one register per edge;
// write only while no transaction is in flight.
// Reset (rst, synchronous): clears all valid bits in flight and loads the
// default registers (identity rotation, zero translation, range 0.25 to
// 2500 m^2, camera not ready). The receiver cannot stall; done is a strobe.
module lidar_point_camera_projection_top
  import lpcp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [COORD_W-1:0]   point_x,
  input  logic signed [COORD_W-1:0]   point_y,
  input  logic signed [COORD_W-1:0]   point_z,
  input  logic                        point_finite,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  output logic                        done,
  output logic [2:0]                  status,
  output logic [PIXEL_COORD_BITS-1:0] pixel_u,
  output logic [PIXEL_COORD_BITS-1:0] pixel_v,
  output logic [DEPTH_W-1:0]          camera_depth
);

  // Configuration registers
  logic [3*COEF_W-1:0]  rot [3];
  logic [3*TRANS_W-1:0] trans;
  logic [CFG_W-1:0]     focal;
  logic [CFG_W-1:0]     range_lim;
  logic [2*DIM_W:0]     image;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0]    <= 54'd65536;
      rot[1]    <= 54'd65536 << COEF_W;
      rot[2]    <= 54'd65536 << (2 * COEF_W);
      trans     <= '0;
      focal     <= '0;
      range_lim <= (64'd640000 << 32) | 64'd64;
      image     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROT_X: rot[0]    <= cfg_data[3*COEF_W-1:0];
        REG_ROT_Y: rot[1]    <= cfg_data[3*COEF_W-1:0];
        REG_ROT_Z: rot[2]    <= cfg_data[3*COEF_W-1:0];
        REG_TRANS: trans     <= cfg_data[3*TRANS_W-1:0];
        REG_FOCAL: focal     <= cfg_data;
        REG_RANGE: range_lim <= cfg_data;
        REG_IMAGE: image     <= cfg_data[2*DIM_W:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: input register
  logic                      v1;
  logic signed [COORD_W-1:0] c1 [3];
  logic                      fin1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start && !busy;
  end

  always_ff @(posedge clk) begin
    c1[0] <= point_x;
    c1[1] <= point_y;
    c1[2] <= point_z;
    fin1  <= point_finite;
  end

  // Stage 2: squares and rotation products, early rejects
  logic                   v2;
  status_t                st2;
  logic [SQ_W-1:0]        sq2 [3];
  logic signed [RP_W-1:0] rp2 [3][3];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (!image[2*DIM_W]) st2 <= ST_NOCAM;
    else if (!fin1)      st2 <= ST_INVALID;
    else                 st2 <= ST_VIEW;
    for (int i = 0; i < 3; i++) begin
      sq2[i] <= SQ_W'(c1[i] * c1[i]);
      for (int j = 0; j < 3; j++) begin
        rp2[i][j] <= RP_W'($signed(rot[i][j*COEF_W +: COEF_W]) * c1[j]);
      end
    end
  end

  // Stage 3: squared norm and camera coordinates
  logic                    v3;
  status_t                 st3;
  logic [SQ_W-1:0]         r2_3;
  logic signed [CAM_W-1:0] cam3 [3];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    st3  <= st2;
    r2_3 <= sq2[0] + sq2[1] + sq2[2];
    for (int i = 0; i < 3; i++) begin
      cam3[i] <= CAM_W'(rp2[i][0]) + CAM_W'(rp2[i][1]) + CAM_W'(rp2[i][2])
               + (CAM_W'($signed(trans[i*TRANS_W +: TRANS_W])) <<< TSH);
    end
  end

  // Stage 4: range gate, behind test, projection products
  logic                    v4;
  status_t                 st4;
  logic signed [CAM_W-1:0] cz4;
  logic signed [PA_W-1:0]  pa4 [2];
  logic signed [PB_W-1:0]  pb4 [2];
  logic [CMP_W-1:0]        lim_mn;
  logic [CMP_W-1:0]        lim_mx;
  logic [CMP_W-1:0]        r2_ext;

  assign lim_mn = CMP_W'(range_lim[31:0]) << LSH;
  assign lim_mx = CMP_W'(range_lim[63:32]) << LSH;
  assign r2_ext = CMP_W'(r2_3);

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (st3 != ST_VIEW)                         st4 <= st3;
    else if (r2_ext < lim_mn || r2_ext > lim_mx) st4 <= ST_RANGE;
    else if (cam3[2] <= 0)                      st4 <= ST_BEHIND;
    else                                        st4 <= ST_VIEW;
    cz4 <= cam3[2];
    for (int a = 0; a < 2; a++) begin
      pa4[a] <= PA_W'($signed({1'b0, focal[a*FOCAL_W +: FOCAL_W]}) * cam3[a]);
      pb4[a] <= PB_W'($signed({1'b0, {1'b0, focal[(a+2)*FOCAL_W +: FOCAL_W]}
                                        + (FOCAL_W+1)'(8)}) * cam3[2]);
    end
  end

  // Stage 5: numerators, divisor, depth
  logic                    v5;
  status_t                 st5;
  logic [DEPTH_W-1:0]      dep5;
  logic [MAG_W-1:0]        mag5 [2];
  logic                    neg5 [2];
  logic [MAG_W-1:0]        den5;
  logic signed [NUM_W-1:0] num4 [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      num4[a] = NUM_W'(pa4[a]) + NUM_W'(pb4[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
  end

  always_ff @(posedge clk) begin
    st5  <= st4;
    den5 <= MAG_W'(cz4) << 4;
    if (|cz4[CAM_W-1:TSH+DEPTH_W]) dep5 <= '1;
    else                           dep5 <= cz4[TSH+DEPTH_W-1:TSH];
    for (int a = 0; a < 2; a++) begin
      neg5[a] <= num4[a] < 0;
      mag5[a] <= (num4[a] < 0) ? MAG_W'(-num4[a]) : MAG_W'(num4[a]);
    end
  end

  // Divider lanes, one per image axis
  logic [Q_W-1:0] quo [2];
  logic           ovf [2];
  logic           negq [2];

  for (genvar a = 0; a < 2; a++) begin : g_div
    lpcp_div u_div (
      .clk     (clk),
      .mag     (mag5[a]),
      .den     (den5),
      .neg     (neg5[a]),
      .quo     (quo[a]),
      .ovf     (ovf[a]),
      .neg_out (negq[a])
    );
  end

  // Sideband delay matching the divider
  logic               vd   [Q_W];
  status_t            std  [Q_W];
  logic [DEPTH_W-1:0] depd [Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Q_W; k++) vd[k] <= 1'b0;
    end else begin
      vd[0] <= v5;
      for (int k = 1; k < Q_W; k++) vd[k] <= vd[k-1];
    end
  end

  always_ff @(posedge clk) begin
    std[0]  <= st5;
    depd[0] <= dep5;
    for (int k = 1; k < Q_W; k++) begin
      std[k]  <= std[k-1];
      depd[k] <= depd[k-1];
    end
  end

  // Final stage: truncation toward zero and bounds check
  logic [CLIP_W-1:0] dim_lim;
  logic [CLIP_W-1:0] dim_clip [2];
  logic [Q_W-1:0]    pix [2];
  logic              out_img;
  status_t           st_f;

  assign dim_lim = CLIP_W'(1) << PIXEL_COORD_BITS;

  always_comb begin
    out_img = 1'b0;
    for (int a = 0; a < 2; a++) begin
      dim_clip[a] = (CLIP_W'(image[a*DIM_W +: DIM_W]) > dim_lim) ?
                    dim_lim : CLIP_W'(image[a*DIM_W +: DIM_W]);
      pix[a] = negq[a] ? '0 : quo[a];
      if (ovf[a] || (negq[a] && quo[a] != '0) || CLIP_W'(pix[a]) >= dim_clip[a]) begin
        out_img = 1'b1;
      end
    end
    if (std[Q_W-1] != ST_VIEW) st_f = std[Q_W-1];
    else if (out_img)          st_f = ST_OUTSIDE;
    else                       st_f = ST_VIEW;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vd[Q_W-1];
  end

  always_ff @(posedge clk) begin
    status  <= st_f;
    pixel_u <= (st_f == ST_VIEW) ? pix[0][PIXEL_COORD_BITS-1:0] : '0;
    pixel_v <= (st_f == ST_VIEW) ? pix[1][PIXEL_COORD_BITS-1:0] : '0;
    camera_depth <= (st_f == ST_VIEW || st_f == ST_OUTSIDE) ? depd[Q_W-1] : '0;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("accepted point did not complete on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without an accepted point");

  a_pix_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_VIEW |-> pixel_u == '0 && pixel_v == '0)
    else $error("pixel fields set on rejected point");

  a_depth_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_NOCAM || status == ST_INVALID || status == ST_RANGE ||
             status == ST_BEHIND) |-> camera_depth == '0)
    else $error("depth set on early reject");
`endif

endmodule
